/* hdl/rslmx_pkg.sv */
// Package for range_second_largest_max_xor: command codes and constants.
// No dependencies.
package rslmx_pkg;
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
endpackage

/* hdl/range_second_largest_max_xor_top.sv */
// channel | dir | transaction contents
// req     | in  | tdata: command, value, left_index, right_index
// rsp     | out | tdata: max_xor, second_largest, valid_res
// A valid query raises rsp_tvalid after two passes over the store at one read per cycle,
// then the drain state and the capture state.
// A load with room gives no response; a bad query or a full-store load answers the next cycle.
// Synchronous reset clears the count and control; the store is not cleared.
// rsp back-pressure holds the result register; req is taken only when idle.
// Depends on rslmx_pkg, rslmx_chain.
module range_second_largest_max_xor_top #(
   parameter int DEPTH = 1024,
   parameter int VALUE_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[0], value[31:1], left_index[41:32], right_index[51:42]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // max_xor[30:0], second_largest[61:31], valid_res[62]
   output logic [63:0] rsp_tdata
);
   import rslmx_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_P1 = 5'b00010, S_P2 = 5'b00100,
      S_DRAIN = 5'b01000, S_OUT = 5'b10000
   } state_type;

   state_type             st_ff, st_in;
   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_ff;
   logic                  rdv_ff;
   logic [CW-1:0]         cnt_ff;
   logic [AW-1:0]         addr_ff, lo_ff, hi_ff;
   logic [1:0]            drain_ff;
   logic                  clear;
   logic                  ov_ff, ook_ff;
   logic [30:0]           ox_ff, os_ff;
   logic [VALUE_BITS-1:0] second, best;
   logic                  acc, cmd;
   logic [30:0]           vin31;
   logic [9:0]            li, ri;
   logic                  bad;

   assign cmd = req_tdata[0];
   assign vin31 = req_tdata[31:1];
   assign li = req_tdata[41:32];
   assign ri = req_tdata[51:42];
   assign req_tready = (st_ff == S_IDLE) && !ov_ff;
   assign acc = req_tvalid && req_tready;
   assign bad = (li >= ri) || (32'(ri) >= 32'(cnt_ff)) || (32'(ri) >= DEPTH);
   assign clear = acc;

   always_ff @(posedge clock) begin
      if (acc && cmd == CMD_LOAD && cnt_ff < CW'(DEPTH)) begin
         mem[cnt_ff[AW-1:0]] <= VALUE_BITS'(vin31);
      end
      rd_ff <= mem[addr_ff];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:  if (acc && cmd == CMD_QUERY && !bad) st_in = S_P1;
         S_P1:    if (addr_ff == hi_ff) st_in = S_P2;
         S_P2:    if (addr_ff == hi_ff) st_in = S_DRAIN;
         S_DRAIN: if (drain_ff == 2'd3) st_in = S_OUT;
         S_OUT:   if (!ov_ff) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         cnt_ff <= '0;
         ov_ff <= 1'b0;
         rdv_ff <= 1'b0;
         drain_ff <= '0;
      end else begin
         st_ff <= st_in;
         rdv_ff <= (st_ff == S_P1) || (st_ff == S_P2);
         drain_ff <= (st_ff == S_DRAIN) ? drain_ff + 2'd1 : 2'd0;
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         if (acc) begin
            if (cmd == CMD_LOAD) begin
               if (cnt_ff < CW'(DEPTH)) cnt_ff <= cnt_ff + 1'b1;
               else ov_ff <= 1'b1;
            end else if (bad) begin
               ov_ff <= 1'b1;
            end
         end
         if (st_ff == S_OUT && !ov_ff) ov_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         addr_ff <= AW'(li);
         lo_ff <= AW'(li);
         hi_ff <= AW'(ri);
         ox_ff <= '0;
         os_ff <= '0;
         ook_ff <= 1'b0;
      end else if (st_ff == S_P1) begin
         addr_ff <= (addr_ff == hi_ff) ? lo_ff : addr_ff + 1'b1;
      end else if (st_ff == S_P2) begin
         addr_ff <= addr_ff + ((addr_ff == hi_ff) ? AW'(0) : AW'(1));
      end
      if (st_ff == S_OUT && !ov_ff) begin
         ox_ff <= 31'(best);
         os_ff <= 31'(second);
         ook_ff <= 1'b1;
      end
   end

   // first read of pass 2 must see pass-1 read phase over; register the pass flag to align it with the read data
   logic p2_d_ff;
   always_ff @(posedge clock) begin
      if (reset) p2_d_ff <= 1'b0;
      else p2_d_ff <= (st_ff == S_P2);
   end

   rslmx_chain #(.VALUE_BITS(VALUE_BITS)) u_chain (
      .clock, .reset, .clear, .pass2(p2_d_ff), .in_vld(rdv_ff),
      .in_val(rd_ff), .second, .best);

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {1'b0, ook_ff, os_ff, ox_ff};

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (acc && cmd == CMD_LOAD && cnt_ff < CW'(DEPTH)) |=> !rsp_tvalid)
      else $error("load produced result");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
endmodule

/* hdl/rslmx_cell.sv */
// One scan cell: keeps the top two values in pass one and the best xor against key in pass two.
// Depends on nothing; used by rslmx_chain.
module rslmx_cell #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  pass2,
   input  logic                  in_vld,
   input  logic [VALUE_BITS-1:0] in_val,
   input  logic [VALUE_BITS-1:0] key,
   output logic [VALUE_BITS-1:0] tally
);
   logic                  have1_ff, have2_ff;
   logic [VALUE_BITS-1:0] t1_ff, t2_ff, b_ff;
   logic [VALUE_BITS-1:0] t1_in, t2_in, b_in, x;
   logic                  have2_in;

   always_comb begin
      t1_in = t1_ff;
      t2_in = t2_ff;
      b_in = b_ff;
      have2_in = have2_ff;
      x = key ^ in_val;
      if (in_vld && !pass2) begin
         if (!have1_ff || in_val > t1_ff) begin
            t2_in = t1_ff;
            have2_in = have1_ff;
            t1_in = in_val;
         end else if (!have2_ff || in_val > t2_ff) begin
            t2_in = in_val;
            have2_in = 1'b1;
         end
      end
      if (in_vld && pass2 && x > b_ff) begin
         b_in = x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have1_ff <= 1'b0;
         have2_ff <= 1'b0;
         t1_ff <= '0;
         t2_ff <= '0;
         b_ff <= '0;
      end else begin
         have1_ff <= have1_ff | (in_vld & !pass2);
         have2_ff <= have2_in;
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         b_ff <= b_in;
      end
   end

   assign tally = pass2 ? b_ff : t2_ff;
endmodule

/* hdl/rslmx_chain.sv */
// Two-cell chain: the memory stream feeds both cells; cell 0 hands its second value to cell 1.
// Cell 0 tracks top two in pass one; cell 1 folds the xor maximum in pass two.
// Depends on rslmx_cell.
module rslmx_chain #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  pass2,
   input  logic                  in_vld,
   input  logic [VALUE_BITS-1:0] in_val,
   output logic [VALUE_BITS-1:0] second,
   output logic [VALUE_BITS-1:0] best
);
   rslmx_cell #(.VALUE_BITS(VALUE_BITS)) u_c0 (
      .clock, .reset, .clear, .pass2(1'b0), .in_vld(in_vld & !pass2), .in_val,
      .key('0), .tally(second));
   rslmx_cell #(.VALUE_BITS(VALUE_BITS)) u_c1 (
      .clock, .reset, .clear, .pass2(1'b1), .in_vld(in_vld & pass2), .in_val,
      .key(second), .tally(best));
endmodule

/* dv/tb_range_second_largest_max_xor_top.sv */
`timescale 1ns / 1ps
// Testbench for range_second_largest_max_xor_top: loads and range queries over the stream ports,
// checked against an in-bench model of the value store. Depends on rslmx_pkg and the block's RTL.
module tb_range_second_largest_max_xor_top;
   import rslmx_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int LIMIT_CYCLES = 3000000;

   typedef struct packed {
      logic        ok;
      logic [30:0] second;
      logic [30:0] max_xor;
   } result_type;

   typedef struct {
      logic        cmd;
      logic [30:0] value;
      logic [9:0]  left;
      logic [9:0]  right;
      bit          typed;
      result_type  answer;
   } step_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;

   logic [30:0] store_model [STORE_DEPTH];
   int          stored_count;
   result_type  pending_results[$];
   int          mismatches;
   bit          quiet;
   bit          hold_request;
   int          hold_left;
   longint      cycles;

   range_second_largest_max_xor_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Update the store model for one transaction; return 1 when a result follows.
   function automatic bit model_step(input logic cmd, input logic [30:0] value,
                                     input logic [9:0] left, input logic [9:0] right,
                                     output result_type res);
      logic [30:0] top1, top2, best, x;
      res = '0;
      if (cmd == CMD_LOAD) begin
         if (stored_count >= STORE_DEPTH) return 1'b1;
         store_model[stored_count] = value;
         stored_count++;
         return 1'b0;
      end
      if (left >= right || right >= stored_count) return 1'b1;
      top1 = store_model[left];
      top2 = store_model[left + 1];
      if (top2 > top1) begin
         top1 = store_model[left + 1];
         top2 = store_model[left];
      end
      for (int i = left + 2; i <= right; i++) begin
         if (store_model[i] > top1) begin
            top2 = top1;
            top1 = store_model[i];
         end else if (store_model[i] > top2) begin
            top2 = store_model[i];
         end
      end
      best = '0;
      for (int i = left; i <= right; i++) begin
         x = top2 ^ store_model[i];
         if (x > best) best = x;
      end
      res.ok = 1'b1;
      res.second = top2;
      res.max_xor = best;
      return 1'b1;
   endfunction

   task automatic send(input logic cmd, input logic [30:0] value, input logic [9:0] left,
                       input logic [9:0] right, input bit typed, input result_type answer);
      result_type res;
      int gap;
      gap = (!quiet && $urandom_range(99) < 8) ? $urandom_range(6, 1) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, right, left, value, cmd};
      do @(posedge clock); while (!req_tready);
      if (model_step(cmd, value, left, right, res))
         pending_results.push_back(typed ? answer : res);
   endtask

   task automatic send_query(input bit in_range);
      logic [9:0] l, r;
      if (in_range && stored_count >= 2) begin
         l = 10'($urandom_range(stored_count - 2));
         r = 10'($urandom_range(stored_count - 1, l + 1));
      end else begin
         l = 10'($urandom_range(1023));
         r = 10'($urandom_range(1023));
      end
      send(CMD_QUERY, 31'($urandom), l, r, 1'b0, '0);
   endtask

   // Receive side: check results, idle at random, honor a requested long hold-off.
   initial begin
      result_type got, want;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[62:0];
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               if (got.ok !== want.ok || got.second !== want.second
                   || got.max_xor !== want.max_xor) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: want ok=%0d second=%h xor=%h ",
                               "got ok=%0d second=%h xor=%h"},
                              want.ok, want.second, want.max_xor,
                              got.ok, got.second, got.max_xor);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || $urandom_range(99) >= 8;
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("tb_range_second_largest_max_xor_top: done, errors");
            $finish;
         end
      end
   end

   initial begin
      step_type steps[$];
      result_type none;
      none = '0;
      steps = '{
         '{CMD_QUERY, 31'h0,        10'd0,    10'd1,    1'b1, none},
         '{CMD_LOAD,  31'h0,        10'd0,    10'd0,    1'b0, none},
         '{CMD_LOAD,  31'h7FFFFFFF, 10'h3FF,  10'h3FF,  1'b0, none},
         '{CMD_QUERY, 31'h7FFFFFFF, 10'd0,    10'd1,    1'b1, '{1'b1, 31'h0, 31'h7FFFFFFF}},
         '{CMD_LOAD,  31'h2AAAAAAA, 10'd0,    10'd0,    1'b0, none},
         '{CMD_LOAD,  31'h55555555, 10'd0,    10'd0,    1'b0, none},
         '{CMD_LOAD,  31'h7FFFFFFF, 10'd0,    10'd0,    1'b0, none},
         '{CMD_LOAD,  31'h40000000, 10'd0,    10'd0,    1'b0, none},
         '{CMD_QUERY, 31'h0,        10'd0,    10'd0,    1'b1, none},
         '{CMD_QUERY, 31'h0,        10'd3,    10'd2,    1'b1, none},
         '{CMD_QUERY, 31'h0,        10'd0,    10'd4,    1'b0, none},
         '{CMD_QUERY, 31'h0,        10'd2,    10'd3,    1'b0, none},
         '{CMD_QUERY, 31'h0,        10'd0,    10'd5,    1'b0, none},
         '{CMD_QUERY, 31'h0,        10'd0,    10'd6,    1'b1, none},
         '{CMD_QUERY, 31'h0,        10'd0,    10'h3FF,  1'b1, none},
         '{CMD_QUERY, 31'h0,        10'h3FF,  10'h3FF,  1'b1, none},
         '{CMD_QUERY, 31'h0,        10'h3FE,  10'h1,    1'b1, none},
         '{CMD_LOAD,  31'h1,        10'd0,    10'd0,    1'b0, none},
         '{CMD_QUERY, 31'h0,        10'd4,    10'd6,    1'b0, none}
      };
      mismatches = 0;
      stored_count = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      hold_left = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i])
         send(steps[i].cmd, steps[i].value, steps[i].left, steps[i].right,
              steps[i].typed, steps[i].answer);

      for (int n = 0; n < 260; n++) begin
         quiet = (n >= 100 && n < 160);
         if (n == 200) hold_request = 1'b1;
         if ($urandom_range(99) < 50)
            send(CMD_LOAD, 31'($urandom), 10'($urandom), 10'($urandom), 1'b0, none);
         else send_query($urandom_range(99) < 80);
      end
      quiet = 1'b0;

      // Queries across the whole index range, at its top end and in its middle, then random in-range queries.
      send(CMD_QUERY, 31'h0, 10'd0, 10'h3FF, 1'b0, none);
      send(CMD_QUERY, 31'h0, 10'h3FE, 10'h3FF, 1'b0, none);
      send(CMD_QUERY, 31'h0, 10'h155, 10'h2AA, 1'b0, none);
      repeat (12) send_query(1'b1);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb_range_second_largest_max_xor_top: done, clean");
      else
         $display("tb_range_second_largest_max_xor_top: done, errors");
      $finish;
   end
endmodule

/* files.f */
hdl/rslmx_pkg.sv
hdl/rslmx_cell.sv
hdl/rslmx_chain.sv
hdl/range_second_largest_max_xor_top.sv
dv/tb_range_second_largest_max_xor_top.sv
